/* src/rot_pkg.sv */
// rot_pkg: shared types and constants of the resource ownership table.
// Request/response structs, request kinds, status codes, field widths.
// No dependencies.
`default_nettype none

package rot_pkg;

    // field widths, fixed by the bus formats
    localparam int OP_W     = 3;
    localparam int ID_W     = 6;
    localparam int VALUE_W  = 32;
    localparam int REQ_W    = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    // bus widths (fields packed from bit 0, padded to bytes)
    localparam int IN_FIELDS_W  = OP_W + ID_W + VALUE_W + REQ_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = STATUS_W + ID_W + VALUE_W + COUNT_W;

    // front-to-back queue
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    // raw opcodes on the bus
    localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
    localparam logic [OP_W-1:0] OP_GET     = 3'd1;
    localparam logic [OP_W-1:0] OP_SET     = 3'd2;
    localparam logic [OP_W-1:0] OP_RESERVE = 3'd3;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;
    localparam logic [OP_W-1:0] OP_LIST    = 3'd5;

    // decoded request kind; undefined opcodes become K_IGNORE
    typedef enum logic [2:0] {
        K_CREATE,
        K_GET,
        K_SET,
        K_RESERVE,
        K_RELEASE,
        K_LIST,
        K_IGNORE
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_OWNED   = 3'd1,
        ST_NO_RES  = 3'd2,
        ST_NOT_RES = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic {
        BS_IDLE,
        BS_EXEC
    } t_bstate;

    typedef struct packed {
        t_kind              kind;
        logic [ID_W-1:0]    id;
        logic [VALUE_W-1:0] data;
        logic [REQ_W-1:0]   who;
    } t_req;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] data;
        logic [ID_W-1:0]    new_id;
        t_status            status;
    } t_rsp;

endpackage

`default_nettype wire

/* src/rot_front.sv */
// rot_front: accepts request transactions and decodes the opcode.
// One register stage feeding the queue. Depends on rot_pkg.
`default_nettype none

module rot_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [rot_pkg::IN_TDATA_W-1:0] i_s_tdata,
    output logic                               o_q_valid,
    input  wire logic                          i_q_ready,
    output rot_pkg::t_req                      o_q_req
);

    logic          r_valid;
    rot_pkg::t_req r_req;
    rot_pkg::t_req n_req;
    logic [rot_pkg::OP_W-1:0] op;

    assign op = i_s_tdata[rot_pkg::OP_W-1:0];

    always_comb begin
        n_req.id   = i_s_tdata[rot_pkg::OP_W +: rot_pkg::ID_W];
        n_req.data = i_s_tdata[rot_pkg::OP_W + rot_pkg::ID_W +: rot_pkg::VALUE_W];
        n_req.who  = i_s_tdata[rot_pkg::OP_W + rot_pkg::ID_W + rot_pkg::VALUE_W +:
                               rot_pkg::REQ_W];
        case (op)
            rot_pkg::OP_CREATE:  n_req.kind = rot_pkg::K_CREATE;
            rot_pkg::OP_GET:     n_req.kind = rot_pkg::K_GET;
            rot_pkg::OP_SET:     n_req.kind = rot_pkg::K_SET;
            rot_pkg::OP_RESERVE: n_req.kind = rot_pkg::K_RESERVE;
            rot_pkg::OP_RELEASE: n_req.kind = rot_pkg::K_RELEASE;
            rot_pkg::OP_LIST:    n_req.kind = rot_pkg::K_LIST;
            default:             n_req.kind = rot_pkg::K_IGNORE;
        endcase
    end

    assign o_s_tready = !r_valid || i_q_ready;
    assign o_q_valid  = r_valid;
    assign o_q_req    = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_req <= n_req;
        end
    end

endmodule

`default_nettype wire

/* src/rot_queue.sv */
// rot_queue: short FIFO of decoded requests between front and back.
// Depends on rot_pkg.
`default_nettype none

module rot_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire rot_pkg::t_req i_req,
    output logic               o_ready,
    input  wire logic          i_pop,
    output logic               o_valid,
    output rot_pkg::t_req      o_req
);

    rot_pkg::t_req                r_buf [rot_pkg::QDEPTH];
    logic [rot_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [rot_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [rot_pkg::QCNT_W-1:0]   r_cnt;
    logic                         push_ok;
    logic                         pop_ok;

    assign o_ready = r_cnt != rot_pkg::QCNT_W'(rot_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_req   = r_buf[r_rd_ptr];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_buf[r_wr_ptr] <= i_req;
        end
    end

endmodule

`default_nettype wire

/* src/rot_back.sv */
// rot_back: executes requests against the entry table and holds the result.
// Value and owner memories, entry count, output register. Depends on rot_pkg.
`default_nettype none

module rot_back #(
    parameter int ENTRIES = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_q_valid,
    input  wire rot_pkg::t_req                   i_q_req,
    output logic                                 o_q_pop,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [rot_pkg::OUT_TDATA_W-1:0]      o_m_tdata
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > rot_pkg::ID_W) ? CNT_W : rot_pkg::ID_W;
    localparam int OWN_W = rot_pkg::REQ_W + 1;  // {held, owner}

    // read data of an entry is only used once it is created, and create writes both words
    logic [rot_pkg::VALUE_W-1:0] r_mem_val [ENTRIES];
    logic [OWN_W-1:0]            r_mem_own [ENTRIES];

    rot_pkg::t_bstate            r_state;
    rot_pkg::t_bstate            n_state;
    rot_pkg::t_req               r_req;
    logic [rot_pkg::VALUE_W-1:0] r_rd_val;
    logic [OWN_W-1:0]            r_rd_own;
    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;
    logic                        r_out_valid;
    rot_pkg::t_rsp               r_out;
    rot_pkg::t_rsp               n_rsp;

    logic                        out_free;
    logic                        do_exec;
    logic [IDX_W-1:0]            rd_idx;
    logic [IDX_W-1:0]            wr_idx;
    logic                        wr_val_en;
    logic                        wr_own_en;
    logic [rot_pkg::VALUE_W-1:0] wr_val;
    logic [OWN_W-1:0]            wr_own;
    logic                        known;
    logic                        full;
    logic                        held;
    logic                        mine;

    assign out_free = !r_out_valid || i_m_tready;
    assign rd_idx   = IDX_W'(i_q_req.id);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rot_pkg::BS_IDLE: if (i_q_valid) n_state = rot_pkg::BS_EXEC;
            rot_pkg::BS_EXEC: if (out_free) n_state = rot_pkg::BS_IDLE;
            default:          n_state = rot_pkg::BS_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop = 1'b0;
        do_exec = 1'b0;
        case (r_state)
            rot_pkg::BS_IDLE: o_q_pop = i_q_valid;
            rot_pkg::BS_EXEC: do_exec = out_free;
            default: begin
                o_q_pop = 1'b0;
                do_exec = 1'b0;
            end
        endcase
    end

    assign known = CMP_W'(r_req.id) < CMP_W'(r_count);
    assign full  = r_count == CNT_W'(ENTRIES);
    assign held  = r_rd_own[OWN_W-1];
    assign mine  = r_rd_own[rot_pkg::REQ_W-1:0] == r_req.who;

    // request resolution
    always_comb begin
        n_rsp     = '0;
        n_count   = r_count;
        wr_idx    = IDX_W'(r_req.id);
        wr_val_en = 1'b0;
        wr_own_en = 1'b0;
        wr_val    = r_req.data;
        wr_own    = {1'b1, r_req.who};
        case (r_req.kind)
            rot_pkg::K_CREATE: begin
                if (full) begin
                    n_rsp.status = rot_pkg::ST_FULL;
                end else begin
                    wr_idx       = IDX_W'(r_count);
                    wr_val_en    = 1'b1;
                    wr_own_en    = 1'b1;
                    wr_own       = '0;
                    n_count      = r_count + 1'b1;
                    n_rsp.new_id = rot_pkg::ID_W'(r_count);
                end
            end
            rot_pkg::K_GET, rot_pkg::K_SET: begin
                if (!known) begin
                    n_rsp.status = rot_pkg::ST_NO_RES;
                end else if (!held) begin
                    n_rsp.status = rot_pkg::ST_NOT_RES;
                end else if (!mine) begin
                    n_rsp.status = rot_pkg::ST_OWNED;
                end else if (r_req.kind == rot_pkg::K_GET) begin
                    n_rsp.data = r_rd_val;
                end else begin
                    wr_val_en = 1'b1;
                end
            end
            rot_pkg::K_RESERVE: begin
                if (!known) begin
                    n_rsp.status = rot_pkg::ST_NO_RES;
                end else if (held && !mine) begin
                    n_rsp.status = rot_pkg::ST_OWNED;
                end else begin
                    wr_own_en = 1'b1;
                end
            end
            rot_pkg::K_RELEASE: begin
                if (!known) begin
                    n_rsp.status = rot_pkg::ST_NO_RES;
                end else if (!held) begin
                    n_rsp.status = rot_pkg::ST_NOT_RES;
                end else if (!mine) begin
                    n_rsp.status = rot_pkg::ST_OWNED;
                end else begin
                    wr_own_en = 1'b1;
                    wr_own    = {1'b0, r_rd_own[rot_pkg::REQ_W-1:0]};
                end
            end
            rot_pkg::K_LIST: n_rsp.count = rot_pkg::COUNT_W'(r_count);
            default:         n_rsp = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rot_pkg::BS_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_req <= i_q_req;
        end
        if (do_exec) begin
            r_out <= n_rsp;
        end
    end

    // table memories: read on pop, write on execute (never the same cycle)
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rd_val <= r_mem_val[rd_idx];
            r_rd_own <= r_mem_own[rd_idx];
        end
        if (do_exec && wr_val_en) begin
            r_mem_val[wr_idx] <= wr_val;
        end
        if (do_exec && wr_own_en) begin
            r_mem_own[wr_idx] <= wr_own;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

endmodule

`default_nettype wire

/* src/resource_ownership_table_unit.sv */
// resource_ownership_table_unit: top level of the resource lock table.
// Instantiates rot_front, rot_queue and rot_back; uses rot_pkg.
//
// channel   dir  tdata fields (bit 0 up)                         width
// s (req)   in   op[2:0] res_id[8:3] data_in[40:9] requester[48:41]  56
// m (rsp)   out  status[2:0] new_id[8:3] data_out[40:9] count[47:41] 48
//
// In the back unit each request is first read from the value/owner memories
// (registered read), then resolved and written back. Reset clears the count
// and control only; no clearing pass is needed since create writes an entry
// before any request may address it. Front register and a 2-deep queue keep
// accepting while the output stalls, until they fill.
`default_nettype none

module resource_ownership_table_unit #(
    parameter int ENTRIES = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // op, res_id, data_in, requester, zero pad
    input  wire logic [rot_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // status, new_id, data_out, entry_count
    output logic [rot_pkg::OUT_TDATA_W-1:0]        o_m_tdata
);

    logic          f_valid;
    logic          q_ready;
    rot_pkg::t_req f_req;
    logic          q_valid;
    logic          q_pop;
    rot_pkg::t_req q_req;

    // accept and decode
    rot_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_q_valid  (f_valid),
        .i_q_ready  (q_ready),
        .o_q_req    (f_req)
    );

    // decouples front from the table unit
    rot_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_req   (f_req),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_req   (q_req)
    );

    // table lookup, update and response register
    rot_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_req    (q_req),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire

/* src/rot_checker.sv */
// rot_checker: port-level assertions for resource_ownership_table_unit.
// Bound to the top level below. Depends on rot_pkg.
`default_nettype none

module rot_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_tvalid,
    input wire logic                            o_s_tready,
    input wire logic [rot_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input wire logic                            o_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic [rot_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    // requests accepted but not yet answered
    logic [3:0] r_pending;
    logic       in_txn;
    logic       out_txn;

    assign in_txn  = i_s_tvalid && o_s_tready;
    assign out_txn = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_txn && !out_txn) begin
            r_pending <= r_pending + 1'b1;
        end else if (out_txn && !in_txn) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("response changed while stalled");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_pending != '0)
        else $error("response without an outstanding request");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[2:0] <= rot_pkg::ST_FULL)
        else $error("status code out of range");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2:0] != rot_pkg::ST_OK
            |-> o_m_tdata[rot_pkg::OUT_TDATA_W-1:3] == '0)
        else $error("failed request returned nonzero fields");

endmodule

bind resource_ownership_table_unit rot_checker u_rot_checker (.*);

`default_nettype wire

/* test/resource_ownership_table_checker.sv */
// Scoreboard for resource_ownership_table_unit: watches the request and response
// stream channels, predicts each response with its own lock table and compares.
// Depends on rot_pkg.
module resource_ownership_table_checker #(
    parameter int ENTRIES = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    input  wire logic                              i_s_tready,
    // op, res_id, data_in, requester, zero pad
    input  wire logic [rot_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  wire logic                              i_m_tvalid,
    input  wire logic                              i_m_tready,
    // status, new_id, data_out, entry_count
    input  wire logic [rot_pkg::OUT_TDATA_W-1:0]   i_m_tdata,
    output int                                     o_mismatches,
    output int                                     o_outstanding
);

    // shadow copy of the lock table
    logic [rot_pkg::VALUE_W-1:0] shadow_value [ENTRIES];
    logic [rot_pkg::REQ_W-1:0]   shadow_owner [ENTRIES];
    logic [ENTRIES-1:0]          shadow_held;
    logic [rot_pkg::COUNT_W-1:0] shadow_count;

    rot_pkg::t_rsp answers_due [$];
    rot_pkg::t_rsp want;
    rot_pkg::t_rsp got;
    int            mismatches = 0;
    int            rsp_index  = 0;

    // Applies one request to the shadow table and returns the response it earns.
    function automatic rot_pkg::t_rsp lock_table_answer(
        input logic [rot_pkg::IN_TDATA_W-1:0] word);
        logic [rot_pkg::OP_W-1:0]    op;
        logic [rot_pkg::ID_W-1:0]    id;
        logic [rot_pkg::VALUE_W-1:0] val;
        logic [rot_pkg::REQ_W-1:0]   who;
        logic                        known;
        rot_pkg::t_rsp               r;
        op    = word[0 +: rot_pkg::OP_W];
        id    = word[rot_pkg::OP_W +: rot_pkg::ID_W];
        val   = word[rot_pkg::OP_W + rot_pkg::ID_W +: rot_pkg::VALUE_W];
        who   = word[rot_pkg::OP_W + rot_pkg::ID_W + rot_pkg::VALUE_W +: rot_pkg::REQ_W];
        known = ({1'b0, id} < shadow_count);
        r        = '0;
        r.status = rot_pkg::ST_OK;
        case (op)
            rot_pkg::OP_CREATE: begin
                if (shadow_count >= ENTRIES) begin
                    r.status = rot_pkg::ST_FULL;
                end else begin
                    shadow_value[shadow_count[rot_pkg::ID_W-1:0]] = val;
                    shadow_owner[shadow_count[rot_pkg::ID_W-1:0]] = '0;
                    shadow_held[shadow_count[rot_pkg::ID_W-1:0]]  = 1'b0;
                    r.new_id     = shadow_count[rot_pkg::ID_W-1:0];
                    shadow_count = shadow_count + 1'b1;
                end
            end
            rot_pkg::OP_GET, rot_pkg::OP_SET: begin
                if (!known)
                    r.status = rot_pkg::ST_NO_RES;
                else if (!shadow_held[id])
                    r.status = rot_pkg::ST_NOT_RES;
                else if (shadow_owner[id] != who)
                    r.status = rot_pkg::ST_OWNED;
                else if (op == rot_pkg::OP_GET)
                    r.data = shadow_value[id];
                else
                    shadow_value[id] = val;
            end
            rot_pkg::OP_RESERVE: begin
                if (!known)
                    r.status = rot_pkg::ST_NO_RES;
                else if (shadow_held[id] && shadow_owner[id] != who)
                    r.status = rot_pkg::ST_OWNED;
                else begin
                    shadow_held[id]  = 1'b1;
                    shadow_owner[id] = who;
                end
            end
            rot_pkg::OP_RELEASE: begin
                if (!known)
                    r.status = rot_pkg::ST_NO_RES;
                else if (!shadow_held[id])
                    r.status = rot_pkg::ST_NOT_RES;
                else if (shadow_owner[id] != who)
                    r.status = rot_pkg::ST_OWNED;
                else
                    shadow_held[id] = 1'b0;
            end
            rot_pkg::OP_LIST: begin
                r.count = shadow_count;
            end
            default: begin
                // spare opcodes: plain ok, nothing touched
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = '0;
            shadow_held  = '0;
            answers_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                answers_due.push_back(lock_table_answer(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = rot_pkg::t_rsp'(i_m_tdata);
                if (answers_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: response %0d arrived with none pending (tdata %h)",
                                 rsp_index, i_m_tdata);
                end else begin
                    want = answers_due.pop_front();
                    if (got.status !== want.status || got.new_id !== want.new_id ||
                        got.data !== want.data || got.count !== want.count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: response %0d: status exp %0d got %0d, ",
                                      "new_id exp %0d got %0d, data exp %h got %h, ",
                                      "count exp %0d got %0d"},
                                     rsp_index, want.status, got.status, want.new_id,
                                     got.new_id, want.data, got.data, want.count, got.count);
                    end
                end
                rsp_index++;
            end
        end
        o_outstanding <= answers_due.size();
        o_mismatches  <= mismatches;
    end

endmodule

/* test/resource_ownership_table_unit_tb.sv */
// Testbench top for resource_ownership_table_unit: drives request transactions
// with bursty timing, stalls the response side, and prints the verdict.
// Depends on rot_pkg, resource_ownership_table_unit and resource_ownership_table_checker.
module resource_ownership_table_unit_tb;

    localparam int ENTRIES      = 64;
    localparam int RANDOM_REQS  = 1080;
    localparam int SETTLE_TICKS = 20;       // well past the response latency

    // the two opcodes the block must ignore
    localparam logic [rot_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [rot_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic [rot_pkg::IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                            i_m_tready = 1'b0;
    logic                            o_s_tready;
    logic                            o_m_tvalid;
    logic [rot_pkg::OUT_TDATA_W-1:0] o_m_tdata;

    int mismatches;
    int outstanding;

    // stimulus bookkeeping only: how many creates the table has taken so far,
    // used to aim ids at existing entries
    int created_n = 0;

    // small pool of client identities so ownership conflicts really happen
    logic [rot_pkg::REQ_W-1:0] clients [4];

    // response-side stall pattern, rotated every cycle until pattern_age runs out, then reloaded
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_age   = 0;

    always #5 i_clk = ~i_clk;

    resource_ownership_table_unit #(
        .ENTRIES (ENTRIES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    resource_ownership_table_checker #(
        .ENTRIES (ENTRIES)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Receiver: modes are always ready, random, sparse, and nearly stuck
    // (one ready in sixteen).
    always @(posedge i_clk) begin
        i_m_tready <= ready_pattern[0];
        if (pattern_age == 0) begin
            pattern_age <= 48;
            case ($urandom_range(0, 3))
                0:       ready_pattern <= 16'hFFFF;
                1:       ready_pattern <= 16'($urandom);
                2:       ready_pattern <= 16'($urandom) & 16'($urandom);
                default: ready_pattern <= 16'h8000;
            endcase
        end else begin
            pattern_age   <= pattern_age - 1;
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
    end

    // One request transaction; returns at the edge where it was accepted.
    // Valid is left high so back-to-back transactions need no extra edge.
    task automatic send_req(input logic [rot_pkg::OP_W-1:0] op,
                            input logic [rot_pkg::ID_W-1:0] id,
                            input logic [rot_pkg::VALUE_W-1:0] data,
                            input logic [rot_pkg::REQ_W-1:0] who);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(rot_pkg::IN_TDATA_W - rot_pkg::IN_FIELDS_W){1'b0}},
                       who, data, id, op};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (op == rot_pkg::OP_CREATE && created_n < ENTRIES)
            created_n++;
    endtask

    // Hold off the sender until every response has come back.
    task automatic drain_all();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Random request, mostly well formed: ids aimed at existing entries and
    // requesters drawn from the client pool; the rest is noise.
    task automatic send_random_req();
        int                          pick;
        logic [rot_pkg::OP_W-1:0]    op;
        logic [rot_pkg::ID_W-1:0]    id;
        logic [rot_pkg::VALUE_W-1:0] data;
        logic [rot_pkg::REQ_W-1:0]   who;
        pick = $urandom_range(0, 99);
        if (pick < 9)
            op = rot_pkg::OP_CREATE;
        else if (pick < 28)
            op = rot_pkg::OP_GET;
        else if (pick < 46)
            op = rot_pkg::OP_SET;
        else if (pick < 68)
            op = rot_pkg::OP_RESERVE;
        else if (pick < 88)
            op = rot_pkg::OP_RELEASE;
        else if (pick < 95)
            op = rot_pkg::OP_LIST;
        else
            op = pick[0] ? OP_SPARE_HI : OP_SPARE_LO;
        if (created_n > 0 && $urandom_range(0, 9) != 0)
            id = rot_pkg::ID_W'($urandom_range(0, created_n - 1));
        else
            id = rot_pkg::ID_W'($urandom);
        case ($urandom_range(0, 7))
            0:       data = '0;
            1:       data = '1;
            default: data = rot_pkg::VALUE_W'($urandom);
        endcase
        if ($urandom_range(0, 6) == 0)
            who = rot_pkg::REQ_W'($urandom);
        else
            who = clients[$urandom_range(0, 3)];
        send_req(op, id, data, who);
    endtask

    initial begin
        int sent;
        int burst;
        int gap;
        clients[0] = 8'h00;
        clients[1] = 8'hFF;
        clients[2] = rot_pkg::REQ_W'($urandom);
        clients[3] = rot_pkg::REQ_W'($urandom);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: empty table, unknown ids, free entries, ownership rules
        send_req(rot_pkg::OP_LIST,    6'd0,  32'h0,        8'h00);  // count on empty table
        send_req(rot_pkg::OP_GET,     6'd0,  32'h0,        8'h00);  // unknown id
        send_req(rot_pkg::OP_RESERVE, 6'd63, 32'hFFFFFFFF, 8'hFF);  // unknown id, top index
        send_req(rot_pkg::OP_CREATE,  6'd63, 32'h0,        8'hFF);  // id 0, zero value
        send_req(rot_pkg::OP_CREATE,  6'd0,  32'hFFFFFFFF, 8'h00);  // id 1, all-ones value
        send_req(rot_pkg::OP_GET,     6'd1,  32'h0,        8'hFF);  // free entry
        send_req(rot_pkg::OP_SET,     6'd1,  32'h12345678, 8'hFF);  // free entry
        send_req(rot_pkg::OP_RELEASE, 6'd0,  32'h0,        8'hFF);  // release of free entry
        send_req(rot_pkg::OP_RESERVE, 6'd1,  32'h0,        8'hFF);  // takes it
        send_req(rot_pkg::OP_RESERVE, 6'd1,  32'h0,        8'hFF);  // re-reserve by holder
        send_req(rot_pkg::OP_RESERVE, 6'd1,  32'h0,        8'h00);  // held by someone else
        send_req(rot_pkg::OP_GET,     6'd1,  32'h0,        8'h00);  // non-owner get
        send_req(rot_pkg::OP_SET,     6'd1,  32'hDEADBEEF, 8'h00);  // non-owner set
        send_req(rot_pkg::OP_RELEASE, 6'd1,  32'h0,        8'h00);  // non-owner release
        send_req(rot_pkg::OP_GET,     6'd1,  32'h0,        8'hFF);  // owner reads all ones
        send_req(rot_pkg::OP_SET,     6'd1,  32'hA5A55A5A, 8'hFF);  // owner writes
        send_req(rot_pkg::OP_GET,     6'd1,  32'h0,        8'hFF);  // and reads back
        send_req(rot_pkg::OP_RELEASE, 6'd1,  32'h0,        8'hFF);  // owner frees
        send_req(rot_pkg::OP_RELEASE, 6'd2,  32'h0,        8'hFF);  // id equal to count
        send_req(rot_pkg::OP_SET,     6'd2,  32'hFFFFFFFF, 8'hFF);  // id equal to count
        send_req(OP_SPARE_LO,         6'd63, 32'hFFFFFFFF, 8'hFF);  // ignored opcode
        send_req(OP_SPARE_HI,         6'd63, 32'hFFFFFFFF, 8'hFF);  // ignored opcode
        send_req(rot_pkg::OP_LIST,    6'd63, 32'hFFFFFFFF, 8'hFF);  // count now two
        drain_all();

        // --- random: bursts of transactions with random gaps; the table fills
        // partway through, so creates hitting a full table are covered too
        sent = 0;
        while (sent < RANDOM_REQS) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < RANDOM_REQS) begin
                send_random_req();
                sent++;
                burst--;
                if (sent == RANDOM_REQS / 2)
                    drain_all();
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        drain_all();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* resource_ownership_table_unit.f */
src/rot_pkg.sv
src/rot_front.sv
src/rot_queue.sv
src/rot_back.sv
src/resource_ownership_table_unit.sv
src/rot_checker.sv
test/resource_ownership_table_checker.sv
test/resource_ownership_table_unit_tb.sv
